>>> hdl/pir_pkg.sv
// Shared types and constants for the pair innovation registry.
// No dependencies; used by pir_pair_store and pair_innovation_registry.
package pir_pkg;

    // Default table depth and stored node-id width
    localparam int TABLE_DEPTH_DEF  = 256;
    localparam int NODE_ID_BITS_DEF = 16;

    // Fixed widths of the request and result fields
    localparam int NODE_FIELD_BITS = 16;
    localparam int INNOV_BITS      = 9;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_PUT
    } t_state;

    // Per-cycle commands from the sequencer to the pair store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_store_ctrl;

endpackage

>>> hdl/pir_pair_store.sv
// Pair store: one synchronous memory of (src, dst) pairs plus the fill count.
// Depends on pir_pkg (t_store_ctrl).
module pir_pair_store #(
    parameter int TABLE_DEPTH  = pir_pkg::TABLE_DEPTH_DEF,
    parameter int NODE_ID_BITS = pir_pkg::NODE_ID_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  pir_pkg::t_store_ctrl                   i_ctrl,
    input  logic [$clog2(TABLE_DEPTH)-1:0]         i_rd_addr,
    input  logic [2*NODE_ID_BITS-1:0]              i_wr_data,
    output logic [2*NODE_ID_BITS-1:0]              o_rd_data,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]       o_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = 2 * NODE_ID_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [DW-1:0] r_mem [TABLE_DEPTH];
    logic [DW-1:0] r_rd_data;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // appends always land at the fill count
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem[r_count[AW-1:0]] <= i_wr_data;
        end
        if (i_ctrl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_ctrl.wr_en) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;

    a_wr_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.wr_en |-> (r_count < DEPTH_C))
        else $error("append into a full table");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.wr_en |=> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("fill count did not advance on append");

    a_rd_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctrl.rd_en && i_ctrl.wr_en))
        else $error("read and append in the same cycle");

endmodule

>>> hdl/pair_innovation_registry.sv
// Pair innovation registry top level: request/result handshakes and scan sequencer.
// Depends on pir_pkg and pir_pair_store.
//
// Keeps (source node, destination node) pairs in order of first sight and
// hands out innovation numbers. Each request carries one pair; the stored
// pairs are scanned from the oldest, one memory read per cycle, each
// compared in the next cycle. A hit returns its 1-based position; a miss
// appends the pair and returns the new count with was_new set; a miss on a
// full table stores nothing and returns 0 with table_full set. Node ids are
// held at NODE_ID_BITS (truncated or zero-extended from the 16-bit ports).
// Timing: one request at a time. An accepted request is scanned, the
// stored pairs being read up to a hit (all of them on a miss), and then
// put: its result is loaded into the output register once that is free.
// The next request can be taken the cycle after the result is loaded.
// The scan through the single read port of the pair memory sets the
// spacing of requests. o_in_stall is high while a request is in work;
// a finished result sits in the output register, so the next request is
// taken while the previous result still waits. The table needs no
// clearing after reset: only entries below the fill count are ever
// read. Innovation numbers carry the low 9 bits of the position.
module pair_innovation_registry #(
    parameter int TABLE_DEPTH  = pir_pkg::TABLE_DEPTH_DEF,
    parameter int NODE_ID_BITS = pir_pkg::NODE_ID_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [pir_pkg::NODE_FIELD_BITS-1:0]  i_src_node,
    input  logic [pir_pkg::NODE_FIELD_BITS-1:0]  i_dst_node,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [pir_pkg::INNOV_BITS-1:0]       o_innovation,
    output logic                                 o_was_new,
    output logic                                 o_table_full
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = NODE_ID_BITS;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    pir_pkg::t_state      r_state, n_state;
    pir_pkg::t_store_ctrl st_ctrl;

    // captured request
    logic [IW-1:0] r_src, n_src;
    logic [IW-1:0] r_dst, n_dst;

    // scan pointers: r_rd_idx is the next entry to read, r_cmp_idx the one
    // whose data is on the memory output when r_cmp_vld is set
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_cmp_idx, n_cmp_idx;
    logic          r_cmp_vld, n_cmp_vld;

    // pending result
    logic [CW-1:0] r_pos, n_pos;
    logic          r_new, n_new;
    logic          r_full, n_full;

    // output register
    logic                          r_out_vld, n_out_vld;
    logic [pir_pkg::INNOV_BITS-1:0] r_out_innov, n_out_innov;
    logic                          r_out_new, n_out_new;
    logic                          r_out_full, n_out_full;
    logic                          out_load;

    logic [2*IW-1:0] st_rd_data;
    logic [CW-1:0]   st_count;
    logic [AW-1:0]   st_rd_addr;
    logic            hit;

    pir_pair_store #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .NODE_ID_BITS (NODE_ID_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (st_ctrl),
        .i_rd_addr (st_rd_addr),
        .i_wr_data ({r_src, r_dst}),
        .o_rd_data (st_rd_data),
        .o_count   (st_count)
    );

    assign st_rd_addr = r_rd_idx[AW-1:0];
    assign hit        = r_cmp_vld && (st_rd_data == {r_src, r_dst});

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_src     = r_src;
        n_dst     = r_dst;
        n_rd_idx  = r_rd_idx;
        n_cmp_idx = r_cmp_idx;
        n_cmp_vld = r_cmp_vld;
        n_pos     = r_pos;
        n_new     = r_new;
        n_full    = r_full;
        st_ctrl   = '0;
        out_load  = 1'b0;

        unique case (r_state)
            pir_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_src     = IW'(i_src_node);
                    n_dst     = IW'(i_dst_node);
                    n_rd_idx  = '0;
                    n_cmp_vld = 1'b0;
                    n_state   = pir_pkg::S_SCAN;
                end
            end
            pir_pkg::S_SCAN: begin
                if (hit) begin
                    n_pos     = r_cmp_idx + 1'b1;
                    n_new     = 1'b0;
                    n_full    = 1'b0;
                    n_cmp_vld = 1'b0;
                    n_state   = pir_pkg::S_PUT;
                end else if (r_rd_idx < st_count) begin
                    st_ctrl.rd_en = 1'b1;
                    n_cmp_idx     = r_rd_idx;
                    n_rd_idx      = r_rd_idx + 1'b1;
                    n_cmp_vld     = 1'b1;
                end else begin
                    // every stored pair checked, no hit
                    n_cmp_vld = 1'b0;
                    n_state   = pir_pkg::S_PUT;
                    if (st_count < DEPTH_C) begin
                        n_pos  = st_count + 1'b1;
                        n_new  = 1'b1;
                        n_full = 1'b0;
                    end else begin
                        n_pos  = '0;
                        n_new  = 1'b0;
                        n_full = 1'b1;
                    end
                end
            end
            pir_pkg::S_PUT: begin
                // append and publish together, once the output register is free
                if (!r_out_vld || !i_out_stall) begin
                    out_load      = 1'b1;
                    st_ctrl.wr_en = r_new;
                    n_state       = pir_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pir_pkg::S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_vld   = r_out_vld && i_out_stall;
        n_out_innov = r_out_innov;
        n_out_new   = r_out_new;
        n_out_full  = r_out_full;
        if (out_load) begin
            n_out_vld   = 1'b1;
            n_out_innov = pir_pkg::INNOV_BITS'(r_pos);
            n_out_new   = r_new;
            n_out_full  = r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pir_pkg::S_IDLE;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src       <= n_src;
        r_dst       <= n_dst;
        r_rd_idx    <= n_rd_idx;
        r_cmp_idx   <= n_cmp_idx;
        r_pos       <= n_pos;
        r_new       <= n_new;
        r_full      <= n_full;
        r_out_innov <= n_out_innov;
        r_out_new   <= n_out_new;
        r_out_full  <= n_out_full;
    end

    assign o_in_stall   = (r_state != pir_pkg::S_IDLE);
    assign o_out_valid  = r_out_vld;
    assign o_innovation = r_out_innov;
    assign o_was_new    = r_out_new;
    assign o_table_full = r_out_full;

    a_new_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pir_pkg::S_PUT) |-> !(r_new && r_full))
        else $error("result flagged both new and full");

    a_append_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pir_pkg::S_PUT && r_new) |-> (r_pos == CW'(st_count + 1'b1)))
        else $error("appended position does not follow the fill count");

    a_read_then_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_ctrl.rd_en |=> (r_cmp_vld && r_state == pir_pkg::S_SCAN))
        else $error("memory read not followed by a compare");

    a_hit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit |-> (r_cmp_idx < st_count))
        else $error("hit on an entry beyond the fill count");

endmodule
